// ----- rtl/bbc_pkg.sv -----
`timescale 1ns / 1ps

package bbc_pkg;

  // default number of stack cells
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // bracket kind held in each stack cell
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  // context codes on the result beat
  localparam logic [1:0] CTX_CODE    = 2'd0;
  localparam logic [1:0] CTX_QUOTE   = 2'd1;
  localparam logic [1:0] CTX_COMMENT = 2'd2;

  // bracket error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // quote modes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // shift command for the stack cell chain
  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stack_op_t;

  // lexer result for one beat
  typedef struct packed {
    logic [1:0] ctx;
    logic [1:0] err;
  } scan_res_t;

endpackage

// ----- rtl/bbc_cell.sv -----
`timescale 1ns / 1ps

module bbc_cell (
  input  logic              clk,
  input  bbc_pkg::stack_op_t op,
  input  bbc_pkg::kind_t    above_i,
  input  bbc_pkg::kind_t    below_i,
  output bbc_pkg::kind_t    data_o
);

  bbc_pkg::kind_t data_r;
  bbc_pkg::kind_t data_nxt;

  // push shifts down from the top side, pop shifts up from the bottom side
  always_comb begin
    data_nxt = data_r;
    if (op.push) begin
      data_nxt = above_i;
    end else if (op.pop) begin
      data_nxt = below_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- rtl/bbc_lexer.sv -----
`timescale 1ns / 1ps

module bbc_lexer #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           ch,
  input  bbc_pkg::kind_t       top_kind,
  output bbc_pkg::stack_op_t   op,
  output bbc_pkg::scan_res_t   res,
  output logic [DW-1:0]        depth_nxt
);

  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  logic [DW-1:0]  depth_r;
  logic [1:0]     quote_r,   quote_nxt;
  logic           comment_r, comment_nxt;
  logic           slash_r,   slash_nxt;
  logic           star_r,    star_nxt;
  bbc_pkg::stack_op_t op_c;

  // classify the byte and work out the next scan state
  always_comb begin
    logic           is_open;
    logic           is_close;
    bbc_pkg::kind_t kind;
    is_open     = 1'b0;
    is_close    = 1'b0;
    kind        = bbc_pkg::KIND_ROUND;
    depth_nxt   = depth_r;
    quote_nxt   = quote_r;
    comment_nxt = comment_r;
    slash_nxt   = 1'b0;
    star_nxt    = 1'b0;
    res.ctx     = bbc_pkg::CTX_CODE;
    res.err     = bbc_pkg::ERR_NONE;
    op_c        = '0;

    case (ch)
      bbc_pkg::CH_LPAREN: begin
        is_open = 1'b1;
        kind    = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_LBRACK: begin
        is_open = 1'b1;
        kind    = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_LBRACE: begin
        is_open = 1'b1;
        kind    = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_RPAREN: begin
        is_close = 1'b1;
        kind     = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_RBRACK: begin
        is_close = 1'b1;
        kind     = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_RBRACE: begin
        is_close = 1'b1;
        kind     = bbc_pkg::KIND_CURLY;
      end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase
    op_c.kind = kind;

    if (comment_r) begin
      // inside a block comment, only star slash ends it
      res.ctx = bbc_pkg::CTX_COMMENT;
      if (star_r && ch == bbc_pkg::CH_STAR) begin
        star_nxt = 1'b1;
      end else if (star_r && ch == bbc_pkg::CH_SLASH) begin
        comment_nxt = 1'b0;
      end else begin
        star_nxt = (ch == bbc_pkg::CH_STAR);
      end
    end else if (quote_r != bbc_pkg::QM_NONE) begin
      // inside a quote, only the matching quote ends it
      res.ctx = bbc_pkg::CTX_QUOTE;
      if ((quote_r == bbc_pkg::QM_SINGLE && ch == bbc_pkg::CH_SQUOTE) ||
          (quote_r == bbc_pkg::QM_DOUBLE && ch == bbc_pkg::CH_DQUOTE)) begin
        quote_nxt = bbc_pkg::QM_NONE;
      end
    end else if (slash_r && ch == bbc_pkg::CH_STAR) begin
      // slash star opens a comment
      res.ctx     = bbc_pkg::CTX_COMMENT;
      comment_nxt = 1'b1;
    end else if (ch == bbc_pkg::CH_SQUOTE || ch == bbc_pkg::CH_DQUOTE) begin
      res.ctx   = bbc_pkg::CTX_QUOTE;
      quote_nxt = (ch == bbc_pkg::CH_SQUOTE) ? bbc_pkg::QM_SINGLE : bbc_pkg::QM_DOUBLE;
    end else begin
      // plain code: bracket handling
      if (is_open) begin
        if (depth_r < FULL) begin
          op_c.push = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end else begin
          res.err = bbc_pkg::ERR_OVERFLOW;
        end
      end else if (is_close) begin
        if (depth_r == '0) begin
          res.err = bbc_pkg::ERR_EMPTY;
        end else begin
          op_c.pop  = 1'b1;
          depth_nxt = depth_r - DW'(1);
          if (top_kind != kind) begin
            res.err = bbc_pkg::ERR_MISMATCH;
          end
        end
      end
      slash_nxt = (ch == bbc_pkg::CH_SLASH);
    end
  end

  // stack moves only on an accepted beat
  always_comb begin
    op      = op_c;
    op.push = op_c.push & accept;
    op.pop  = op_c.pop & accept;
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      quote_r   <= bbc_pkg::QM_NONE;
      comment_r <= 1'b0;
      slash_r   <= 1'b0;
      star_r    <= 1'b0;
    end else if (accept) begin
      depth_r   <= depth_nxt;
      quote_r   <= quote_nxt;
      comment_r <= comment_nxt;
      slash_r   <= slash_nxt;
      star_r    <= star_nxt;
    end
  end

endmodule

// ----- rtl/bracket_balance_checker_unit.sv -----
`timescale 1ns / 1ps
// the result of each input beat is held in one output register
// throughput: one byte per cycle while not stalled; the stack is a chain of shift
//   cells whose top cell is always at hand, so a byte does its single push or pop
// reset: synchronous active-low rst_n clears depth, quote, comment and slash/star
//   flags and the output valid; stack cell contents are not reset

module bracket_balance_checker_unit #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_echo,
  output logic [1:0] out_context_res,
  output logic [1:0] out_bracket_error,
  output logic [6:0] out_open_depth
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic               accept;
  bbc_pkg::stack_op_t op;
  bbc_pkg::scan_res_t res;
  logic [DW-1:0]      depth_nxt;
  bbc_pkg::kind_t     cell_q [STACK_DEPTH];

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         echo_r;
  logic [1:0]         ctx_r;
  logic [1:0]         err_r;
  logic [6:0]         depth_r;

  // input handshake: blocked only while a result beat waits on a stalled sink
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  bbc_lexer #(
    .STACK_DEPTH(STACK_DEPTH),
    .DW         (DW)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .ch       (in_ch),
    .top_kind (cell_q[0]),
    .op       (op),
    .res      (res),
    .depth_nxt(depth_nxt)
  );

  // bracket stack as a chain of cells, cell 0 holds the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bbc_pkg::kind_t above;
    bbc_pkg::kind_t below;
    if (i == 0) begin : g_top
      assign above = op.kind;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = bbc_pkg::KIND_ROUND;
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    bbc_cell u_cell (
      .clk    (clk),
      .op     (op),
      .above_i(above),
      .below_i(below),
      .data_o (cell_q[i])
    );
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      echo_r  <= in_ch;
      ctx_r   <= res.ctx;
      err_r   <= res.err;
      depth_r <= 7'(depth_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_echo          = echo_r;
  assign out_context_res   = ctx_r;
  assign out_bracket_error = err_r;
  assign out_open_depth    = depth_r;

`ifndef ASSERT_OFF
  // the stack never pushes and pops in the same cycle
  a_op_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.push && op.pop))
    else $error("stack push and pop together");

  // depth never runs past the number of cells
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_nxt <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // an overflow beat always reports a full stack
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r == bbc_pkg::ERR_OVERFLOW) |-> depth_r == 7'(STACK_DEPTH))
    else $error("overflow reported with stack not full");

  // an accepted beat shows up as a valid result next cycle
  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");
`endif

endmodule
